// ===== design/nearest_vector_threshold_search_macros.svh =====
// Assertion macros used by the nearest vector threshold search top-level design file.
`ifndef NEAREST_VECTOR_THRESHOLD_SEARCH_MACROS_SVH
`define NEAREST_VECTOR_THRESHOLD_SEARCH_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define NVTS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define NVTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define NVTS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nvts_pkg.sv =====
// Package with widths, codes and default sizes of the nearest vector threshold search.
package nvts_pkg;

    // Default sizes of the stored vector table.
    localparam int DEF_MAX_VECTORS   = 32;
    localparam int DEF_MAX_LENGTH    = 4096;
    localparam int DEF_ELEMENT_WIDTH = 16;

    // Fixed field and register widths.
    localparam int KIND_W      = 2;
    localparam int ID_W        = 8;
    localparam int DIST_W      = 44;
    localparam int LEN_REG_W   = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 44;

    // A magnitude at or above 2^MAG_W squares to more than the distance range.
    localparam int MAG_W = 22;

    localparam logic [DIST_W-1:0]    DIST_MAX  = '1;
    localparam logic [LEN_REG_W-1:0] LEN_RESET = 13'd4096;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } nvts_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD = 1'b0,
        REG_LENGTH    = 1'b1
    } nvts_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } nvts_state_t;

endpackage

// ===== design/nvts_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module nvts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/nearest_vector_threshold_search.sv =====
// Top level of the nearest stored vector search with a distance threshold.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  kind, person_id, value, last
// out       output     out_valid/out_stall  found, match_person, match_distance
// cfg       input      cfg_write            cfg_index, cfg_data
//
// A load, a clear or an ignored kind is accepted in idle and leaves the block idle.
// A query element on a nonempty table holds the input stalled for a pass of the
// one shared distance unit, which visits the stored vectors one per cycle through
// the read port of the vector record RAM; after the pass of a last query element,
// or a last query element on an empty table, the done state loads the output register.
// Reset clears only control state and starts no clearing pass: record RAM entries
// come into use only once a load has closed them.
// The result waits in an output register, so the next item is accepted while it
// is stalled; a later result waits in its own state until that register frees.
`include "nearest_vector_threshold_search_macros.svh"

module nearest_vector_threshold_search #(
    parameter int MAX_VECTORS   = nvts_pkg::DEF_MAX_VECTORS,
    parameter int MAX_LENGTH    = nvts_pkg::DEF_MAX_LENGTH,
    parameter int ELEMENT_WIDTH = nvts_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input item channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [nvts_pkg::KIND_W-1:0]         kind,
    input  logic [nvts_pkg::ID_W-1:0]           person_id,
    input  logic signed [ELEMENT_WIDTH-1:0]     value,
    input  logic                                last,
    // Result item channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [nvts_pkg::ID_W-1:0]           match_person,
    output logic [nvts_pkg::DIST_W-1:0]         match_distance,
    // Configuration write port.
    input  logic                                cfg_write,
    input  logic [nvts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nvts_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DIST_W    = nvts_pkg::DIST_W;
    localparam int ID_W      = nvts_pkg::ID_W;
    localparam int MAG_W     = nvts_pkg::MAG_W;
    localparam int V_W       = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int CNT_V_W   = $clog2(MAX_VECTORS + 1);
    localparam int POS_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CNT_LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int REC_W     = ID_W + CNT_LEN_W + DIST_W;
    localparam int ELEM_DEPTH = MAX_VECTORS * (2 ** POS_W);
    localparam int EA_W      = (ELEM_DEPTH > 1) ? $clog2(ELEM_DEPTH) : 1;
    localparam int DW        = ELEMENT_WIDTH + 1;

    localparam logic [DW-1:0]        DIFF_ONE = 1;
    localparam logic [CNT_LEN_W-1:0] LEN_ONE  = 1;
    localparam logic [CNT_V_W-1:0]   CNT_ONE  = 1;
    localparam logic [V_W-1:0]       V_ONE    = 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    nvts_pkg::nvts_state_t state_reg, state_next;

    logic [DIST_W-1:0]                 thr_reg;
    logic [nvts_pkg::LEN_REG_W-1:0]    vl_reg;
    logic [CNT_V_W-1:0]                count_reg;
    logic [CNT_LEN_W-1:0]              load_pos_reg;
    logic [CNT_LEN_W-1:0]              query_pos_reg;

    // Snapshot of the query element being processed.
    logic signed [ELEMENT_WIDTH-1:0]   q_value_reg;
    logic                              q_last_reg;
    logic                              q_active_reg;
    logic [CNT_LEN_W-1:0]              q_pos_reg;

    // Issue counter and the stages of the shared distance unit.
    logic                              issue_active_reg;
    logic [V_W-1:0]                    issue_v_reg;
    logic                              s1_valid_reg, s1_last_reg;
    logic [V_W-1:0]                    s1_v_reg;
    logic                              s2_valid_reg, s2_last_reg, s2_upd_reg, s2_sat_reg;
    logic [V_W-1:0]                    s2_v_reg;
    logic [MAG_W-1:0]                  s2_mag_reg;
    logic [ID_W-1:0]                   s2_owner_reg;
    logic [CNT_LEN_W-1:0]              s2_len_reg;
    logic [DIST_W-1:0]                 s2_dist_reg;
    logic                              s3_valid_reg, s3_last_reg, s3_upd_reg;
    logic [V_W-1:0]                    s3_v_reg;
    logic [DIST_W-1:0]                 s3_sq_reg;
    logic [ID_W-1:0]                   s3_owner_reg;
    logic [CNT_LEN_W-1:0]              s3_len_reg;
    logic [DIST_W-1:0]                 s3_dist_reg;
    logic                              s4_valid_reg, s4_last_reg;
    logic [V_W-1:0]                    s4_v_reg;
    logic [ID_W-1:0]                   s4_owner_reg;
    logic [CNT_LEN_W-1:0]              s4_len_reg;
    logic [DIST_W-1:0]                 s4_dist_reg;

    // Running best match of the current query.
    logic                              best_found_reg;
    logic [DIST_W-1:0]                 best_dist_reg;
    logic [ID_W-1:0]                   best_person_reg;

    // Output register.
    logic                              out_valid_reg;
    logic                              found_reg;
    logic [ID_W-1:0]                   match_person_reg;
    logic [DIST_W-1:0]                 match_distance_reg;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                 in_accept;
    logic                 is_load, is_query, is_clear;
    logic                 out_free;
    logic [CNT_LEN_W-1:0] eff_len;
    logic                 table_full;
    logic                 load_store;
    logic [CNT_LEN_W-1:0] load_len;

    logic                 elem_we, elem_re;
    logic [EA_W-1:0]      elem_waddr, elem_raddr;
    logic [ELEMENT_WIDTH-1:0] elem_rdata;
    logic                 rec_we, rec_re;
    logic [V_W-1:0]       rec_waddr, rec_raddr;
    logic [REC_W-1:0]     rec_wdata, rec_rdata;

    logic [ID_W-1:0]      rd_owner;
    logic [CNT_LEN_W-1:0] rd_len;
    logic [DIST_W-1:0]    rd_dist;
    logic [DW-1:0]        diff;
    logic [DW-1:0]        mag;
    logic [DW+MAG_W-1:0]  mag_ext;
    logic [DIST_W-1:0]    prod;
    logic [DIST_W:0]      sum;
    logic [DIST_W-1:0]    new_dist;
    logic                 better;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Item kind decode; an unknown kind is accepted and ignored.
    always_comb
    begin
        is_load  = 1'b0;
        is_query = 1'b0;
        is_clear = 1'b0;
        unique case (kind)
            nvts_pkg::KIND_LOAD:  is_load  = 1'b1;
            nvts_pkg::KIND_QUERY: is_query = 1'b1;
            nvts_pkg::KIND_CLEAR: is_clear = 1'b1;
            default:              ;
        endcase
    end

    // Effective vector length: zero counts as one, and the table depth caps it.
    always_comb
    begin
        if (vl_reg == '0)
        begin
            eff_len = LEN_ONE;
        end
        else if (14'(vl_reg) > 14'(MAX_LENGTH))
        begin
            eff_len = CNT_LEN_W'(MAX_LENGTH);
        end
        else
        begin
            eff_len = CNT_LEN_W'(vl_reg);
        end
    end

    assign table_full = (count_reg == CNT_V_W'(MAX_VECTORS));
    assign load_store = (load_pos_reg < eff_len);
    assign load_len   = load_store ? (load_pos_reg + LEN_ONE) : load_pos_reg;

    // ------------------------------------------------------------------
    // State machine: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nvts_pkg::ST_IDLE:
            begin
                if (in_accept && is_query)
                begin
                    if (count_reg != '0)
                    begin
                        state_next = nvts_pkg::ST_RUN;
                    end
                    else if (last)
                    begin
                        state_next = nvts_pkg::ST_DONE;
                    end
                end
            end
            nvts_pkg::ST_RUN:
            begin
                if (s4_valid_reg && s4_last_reg)
                begin
                    state_next = q_last_reg ? nvts_pkg::ST_DONE : nvts_pkg::ST_IDLE;
                end
            end
            nvts_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = nvts_pkg::ST_IDLE;
                end
            end
            default: state_next = nvts_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State machine: outputs and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall   = (state_reg != nvts_pkg::ST_IDLE);

        // Element writes come from loads only.
        elem_we    = in_accept && is_load && !table_full && load_store;
        elem_waddr = EA_W'({count_reg[V_W-1:0], load_pos_reg[POS_W-1:0]});
        elem_re    = (state_reg == nvts_pkg::ST_RUN) && issue_active_reg;
        elem_raddr = EA_W'({issue_v_reg, q_pos_reg[POS_W-1:0]});
        rec_re     = elem_re;
        rec_raddr  = issue_v_reg;

        // The record port is shared: a closing load in idle, write-back in a pass.
        if (s4_valid_reg)
        begin
            rec_we    = 1'b1;
            rec_waddr = s4_v_reg;
            rec_wdata = {s4_owner_reg, s4_len_reg, q_last_reg ? '0 : s4_dist_reg};
        end
        else
        begin
            rec_we    = in_accept && is_load && !table_full && last;
            rec_waddr = count_reg[V_W-1:0];
            rec_wdata = {person_id, load_len, {DIST_W{1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // Shared distance unit
    // ------------------------------------------------------------------
    assign rd_owner = rec_rdata[REC_W-1 -: ID_W];
    assign rd_len   = rec_rdata[DIST_W +: CNT_LEN_W];
    assign rd_dist  = rec_rdata[DIST_W-1:0];

    // Exact difference one bit wider than an element, then its magnitude.
    assign diff    = {q_value_reg[ELEMENT_WIDTH-1], q_value_reg}
                   - {elem_rdata[ELEMENT_WIDTH-1], elem_rdata};
    assign mag     = diff[DW-1] ? (~diff + DIFF_ONE) : diff;
    assign mag_ext = {{MAG_W{1'b0}}, mag};

    assign prod = s2_mag_reg * s2_mag_reg;

    // The carry of the sum is the saturation condition.
    assign sum      = {1'b0, s3_dist_reg} + {1'b0, s3_sq_reg};
    assign new_dist = !s3_upd_reg ? s3_dist_reg
                    : (sum[DIST_W] ? nvts_pkg::DIST_MAX : sum[DIST_W-1:0]);

    // Strict compares keep the earliest vector on ties.
    assign better = (s4_dist_reg < thr_reg) && (!best_found_reg || (s4_dist_reg < best_dist_reg));

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= nvts_pkg::ST_IDLE;
            thr_reg          <= nvts_pkg::DIST_MAX;
            vl_reg           <= nvts_pkg::LEN_RESET;
            count_reg        <= '0;
            load_pos_reg     <= '0;
            query_pos_reg    <= '0;
            issue_active_reg <= 1'b0;
            issue_v_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            best_found_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    nvts_pkg::REG_THRESHOLD: thr_reg <= cfg_data[DIST_W-1:0];
                    nvts_pkg::REG_LENGTH:    vl_reg  <= cfg_data[nvts_pkg::LEN_REG_W-1:0];
                    default:                 ;
                endcase
            end

            if (in_accept && is_load && !table_full)
            begin
                if (last)
                begin
                    count_reg    <= count_reg + CNT_ONE;
                    load_pos_reg <= '0;
                end
                else if (load_store)
                begin
                    load_pos_reg <= load_pos_reg + LEN_ONE;
                end
            end

            if (in_accept && is_clear)
            begin
                count_reg     <= '0;
                load_pos_reg  <= '0;
                query_pos_reg <= '0;
            end

            if (in_accept && is_query)
            begin
                if (last)
                begin
                    query_pos_reg <= '0;
                end
                else if (query_pos_reg < eff_len)
                begin
                    query_pos_reg <= query_pos_reg + LEN_ONE;
                end
                issue_active_reg <= (count_reg != '0);
                issue_v_reg      <= '0;
                best_found_reg   <= 1'b0;
            end
            else if (elem_re)
            begin
                issue_v_reg <= issue_v_reg + V_ONE;
                if (CNT_V_W'(issue_v_reg) + CNT_ONE == count_reg)
                begin
                    issue_active_reg <= 1'b0;
                end
            end

            s1_valid_reg <= elem_re;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;

            if (s4_valid_reg && better)
            begin
                best_found_reg <= 1'b1;
            end

            if ((state_reg == nvts_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept && is_query)
        begin
            q_value_reg     <= value;
            q_last_reg      <= last;
            q_active_reg    <= (query_pos_reg < eff_len);
            q_pos_reg       <= query_pos_reg;
            best_dist_reg   <= '0;
            best_person_reg <= '0;
        end

        s1_v_reg    <= issue_v_reg;
        s1_last_reg <= (CNT_V_W'(issue_v_reg) + CNT_ONE == count_reg);

        s2_v_reg     <= s1_v_reg;
        s2_last_reg  <= s1_last_reg;
        s2_upd_reg   <= q_active_reg && (q_pos_reg < rd_len);
        s2_sat_reg   <= |mag_ext[DW+MAG_W-1:MAG_W];
        s2_mag_reg   <= mag_ext[MAG_W-1:0];
        s2_owner_reg <= rd_owner;
        s2_len_reg   <= rd_len;
        s2_dist_reg  <= rd_dist;

        s3_v_reg     <= s2_v_reg;
        s3_last_reg  <= s2_last_reg;
        s3_upd_reg   <= s2_upd_reg;
        s3_sq_reg    <= s2_sat_reg ? nvts_pkg::DIST_MAX : prod;
        s3_owner_reg <= s2_owner_reg;
        s3_len_reg   <= s2_len_reg;
        s3_dist_reg  <= s2_dist_reg;

        s4_v_reg     <= s3_v_reg;
        s4_last_reg  <= s3_last_reg;
        s4_owner_reg <= s3_owner_reg;
        s4_len_reg   <= s3_len_reg;
        s4_dist_reg  <= new_dist;

        if (s4_valid_reg && better)
        begin
            best_dist_reg   <= s4_dist_reg;
            best_person_reg <= s4_owner_reg;
        end

        if ((state_reg == nvts_pkg::ST_DONE) && out_free)
        begin
            found_reg          <= best_found_reg;
            match_person_reg   <= best_person_reg;
            match_distance_reg <= best_dist_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_person   = match_person_reg;
    assign match_distance = match_distance_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    nvts_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (ELEM_DEPTH)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (value),
        .re    (elem_re),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    nvts_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_VECTORS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `NVTS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_V_W'(MAX_VECTORS), "table count overflow")
    `NVTS_ASSERT_ALWAYS(a_qpos_bound, query_pos_reg <= CNT_LEN_W'(MAX_LENGTH), "query position overflow")
    `NVTS_ASSERT_IMP(a_wb_in_run, s4_valid_reg, state_reg == nvts_pkg::ST_RUN, "write-back outside a pass")
    `NVTS_ASSERT_IMP(a_miss_zero, out_valid_reg && !found_reg, (match_distance_reg == '0) && (match_person_reg == '0), "miss with nonzero payload")
    `NVTS_ASSERT_NXT(a_done_loads, (state_reg == nvts_pkg::ST_DONE) && out_free, out_valid_reg, "result not loaded")

endmodule
